>>> rtl/core/ffra_pkg.sv
package ffra_pkg;

    localparam int MAX_SLOTS = 4096;
    localparam int SW        = 13;
    localparam int WORD_BITS = 8;
    localparam int NUM_WORDS = MAX_SLOTS / WORD_BITS;
    localparam int WA_W      = $clog2(NUM_WORDS);
    localparam int WB_W      = $clog2(WORD_BITS);

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef struct packed {
        logic cfg_we;
        logic item_load;
        logic clr_wr;
        logic scan_init;
        logic scan_step;
        logic rd_en;
        logic set_range;
        logic upd_wr;
        logic res_ok;
        logic res_fail;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic bad;
        logic is_free;
        logic scan_hit;
        logic scan_end;
        logic upd_last;
    } t_stat;

endpackage

>>> rtl/core/ffra_if.sv
interface ffra_item_if;
    import ffra_pkg::*;
    logic          valid;
    logic          ready;
    logic          operation;
    logic [SW-1:0] run_length;
    logic [SW-1:0] start_slot;
    modport source (output valid, operation, run_length, start_slot, input ready);
    modport sink   (input valid, operation, run_length, start_slot, output ready);
endinterface

interface ffra_res_if;
    import ffra_pkg::*;
    logic          valid;
    logic          ready;
    logic [SW-1:0] found_start;
    logic          ok;
    modport source (output valid, found_start, ok, input ready);
    modport sink   (input valid, found_start, ok, output ready);
endinterface

interface ffra_cfg_if;
    import ffra_pkg::*;
    logic          valid;
    logic          ready;
    logic [SW-1:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

>>> rtl/core/first_fit_run_allocator_unit.sv
// channel   dir  beat
// i_cfg     in   room_count write (data)
// i_item    in   operation, run_length, start_slot
// o_result  out  found_start, ok
//
// Slot map is a 512 x 8 bit occupancy memory; each word visited is first read, then scanned or rewritten.
// Allocate: check, then read and scan words until a run fits, then read and rewrite the words it covers.
// Free: check, then read and rewrite the words in the range. Rejected items go from the check to the result.
// After reset and each room_count write a clearing pass zeroes all 512 words.
// Result is held until taken; no new item is taken meanwhile.
module first_fit_run_allocator_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ffra_cfg_if.sink   i_cfg,
    ffra_item_if.sink  i_item,
    ffra_res_if.source o_result
);
    import ffra_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    ffra_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg.valid),
        .i_in_valid  (i_item.valid),
        .i_out_ready (o_result.ready),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_cfg_ready (i_cfg.ready),
        .o_in_ready  (i_item.ready),
        .o_out_valid (o_result.valid)
    );

    ffra_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_data    (i_cfg.data),
        .i_operation   (i_item.operation),
        .i_run_length  (i_item.run_length),
        .i_start_slot  (i_item.start_slot),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_found_start (o_result.found_start),
        .o_ok          (o_result.ok)
    );

endmodule

>>> rtl/core/ffra_datapath.sv
module ffra_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [ffra_pkg::SW-1:0] i_cfg_data,
    input  logic                 i_operation,
    input  logic [ffra_pkg::SW-1:0] i_run_length,
    input  logic [ffra_pkg::SW-1:0] i_start_slot,
    input  ffra_pkg::t_cmd       i_cmd,
    output ffra_pkg::t_stat      o_stat,
    output logic [ffra_pkg::SW-1:0] o_found_start,
    output logic                 o_ok
);
    import ffra_pkg::*;

    logic [WORD_BITS-1:0] r_mem [NUM_WORDS];
    logic [WORD_BITS-1:0] r_rdata;
    logic [WA_W-1:0]      r_addr, n_addr;
    logic [SW-1:0]        r_room;
    logic                 r_op;
    logic [SW-1:0]        r_len, r_start, r_run, r_rstart, r_lo, r_hi;
    logic [SW-1:0]        r_found;
    logic                 r_ok;

    logic [SW-1:0]        base, s, sm, run, rst_s, fnd, lo_v, hi_v;
    logic [SW:0]          sum;
    logic                 hit, fr;
    logic [WORD_BITS-1:0] mask, wdata;
    logic                 mem_we;
    logic [SW-1:0]        cfg_v;

    assign base = SW'({r_addr, {WB_W{1'b0}}});

    always_comb begin
        run   = r_run;
        rst_s = r_rstart;
        hit   = 1'b0;
        fnd   = '0;
        for (int b = 0; b < WORD_BITS; b++) begin
            s  = base + SW'(b + 1);
            fr = !r_rdata[b] && (s <= r_room);
            if (!hit) begin
                if (fr) begin
                    if (run == '0) rst_s = s;
                    run = run + SW'(1);
                    if (run == r_len) begin
                        hit = 1'b1;
                        fnd = rst_s;
                    end
                end else begin
                    run = '0;
                end
            end
        end
    end

    always_comb begin
        sum = {1'b0, r_start} + {1'b0, r_len} - (SW+1)'(1);
        if (r_op == OP_FREE) begin
            lo_v = r_start;
            hi_v = (sum > {1'b0, r_room}) ? r_room : sum[SW-1:0];
        end else begin
            lo_v = fnd;
            hi_v = fnd + r_len - SW'(1);
        end
    end

    always_comb begin
        for (int b = 0; b < WORD_BITS; b++) begin
            sm      = base + SW'(b + 1);
            mask[b] = (sm >= r_lo) && (sm <= r_hi);
        end
        wdata = (r_op == OP_FREE) ? (r_rdata & ~mask) : (r_rdata | mask);
    end

    always_comb begin
        cfg_v = i_cfg_data;
        if (i_cfg_data == '0) cfg_v = SW'(1);
        else if (i_cfg_data > SW'(MAX_SLOTS)) cfg_v = SW'(MAX_SLOTS);
    end

    always_comb begin
        n_addr = r_addr;
        if (i_cmd.cfg_we || i_cmd.scan_init) n_addr = '0;
        else if (i_cmd.set_range) n_addr = WA_W'((lo_v - SW'(1)) >> WB_W);
        else if (i_cmd.clr_wr || i_cmd.scan_step || i_cmd.upd_wr) n_addr = r_addr + WA_W'(1);
    end

    assign mem_we = i_cmd.clr_wr || i_cmd.upd_wr;

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[r_addr] <= i_cmd.clr_wr ? '0 : wdata;
        if (i_cmd.rd_en) r_rdata <= r_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= '0;
            r_room <= SW'(MAX_SLOTS);
        end else begin
            r_addr <= n_addr;
            if (i_cmd.cfg_we) r_room <= cfg_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.item_load) begin
            r_op    <= i_operation;
            r_len   <= i_run_length;
            r_start <= i_start_slot;
        end
        if (i_cmd.scan_init) begin
            r_run    <= '0;
            r_rstart <= '0;
        end else if (i_cmd.scan_step) begin
            r_run    <= run;
            r_rstart <= rst_s;
        end
        if (i_cmd.set_range) begin
            r_lo <= lo_v;
            r_hi <= hi_v;
        end
        if (i_cmd.res_ok) begin
            r_ok    <= 1'b1;
            r_found <= (r_op == OP_ALLOC) ? r_lo : '0;
        end else if (i_cmd.res_fail) begin
            r_ok    <= 1'b0;
            r_found <= '0;
        end
    end

    assign o_stat.clr_last = (r_addr == WA_W'(NUM_WORDS - 1));
    assign o_stat.bad      = (r_len == '0) ||
                             ((r_op == OP_ALLOC) ? (r_len > r_room)
                                                 : ((r_start == '0) || (r_start > r_room)));
    assign o_stat.is_free  = (r_op == OP_FREE);
    assign o_stat.scan_hit = hit;
    assign o_stat.scan_end = ({1'b0, base} + (SW+1)'(WORD_BITS)) >= {1'b0, r_room};
    assign o_stat.upd_last = (r_addr == WA_W'((r_hi - SW'(1)) >> WB_W));

    assign o_found_start = r_found;
    assign o_ok          = r_ok;

endmodule

>>> rtl/core/ffra_ctrl.sv
module ffra_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_valid,
    input  logic            i_in_valid,
    input  logic            i_out_ready,
    input  ffra_pkg::t_stat i_stat,
    output ffra_pkg::t_cmd  o_cmd,
    output logic            o_cfg_ready,
    output logic            o_in_ready,
    output logic            o_out_valid
);
    import ffra_pkg::*;

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_CHK  = 3'd2;
    localparam logic [2:0] S_SRD  = 3'd3;
    localparam logic [2:0] S_SSC  = 3'd4;
    localparam logic [2:0] S_URD  = 3'd5;
    localparam logic [2:0] S_UWR  = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    logic [2:0] r_state, n_state;

    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_in_ready  = (r_state == S_IDLE) && !i_cfg_valid;
    assign o_out_valid = (r_state == S_DONE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_stat.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_cfg_valid) begin
                    o_cmd.cfg_we = 1'b1;
                    n_state      = S_CLR;
                end else if (i_in_valid) begin
                    o_cmd.item_load = 1'b1;
                    n_state         = S_CHK;
                end
            end
            S_CHK: begin
                if (i_stat.bad) begin
                    o_cmd.res_fail = 1'b1;
                    n_state        = S_DONE;
                end else if (i_stat.is_free) begin
                    o_cmd.set_range = 1'b1;
                    n_state         = S_URD;
                end else begin
                    o_cmd.scan_init = 1'b1;
                    n_state         = S_SRD;
                end
            end
            S_SRD: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_SSC;
            end
            S_SSC: begin
                if (i_stat.scan_hit) begin
                    o_cmd.set_range = 1'b1;
                    n_state         = S_URD;
                end else if (i_stat.scan_end) begin
                    o_cmd.res_fail = 1'b1;
                    n_state        = S_DONE;
                end else begin
                    o_cmd.scan_step = 1'b1;
                    n_state         = S_SRD;
                end
            end
            S_URD: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_UWR;
            end
            S_UWR: begin
                o_cmd.upd_wr = 1'b1;
                if (i_stat.upd_last) begin
                    o_cmd.res_ok = 1'b1;
                    n_state      = S_DONE;
                end else begin
                    n_state = S_URD;
                end
            end
            S_DONE: begin
                if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef SYNTHESIS
    a_in_chk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_CHK))
        else $error("accepted beat not checked");
    a_cfg_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && o_cfg_ready) |=> (r_state == S_CLR))
        else $error("config write without clear");
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input taken while result pending");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid)
        else $error("result dropped");
`endif

endmodule
